// ===== rtl/rmq_pkg.sv =====
// shared types, codes and width helpers for the rotation matrix to quaternion block
// no dependencies
`default_nettype none

package rmq_pkg;

    localparam int FIELD_W           = 18;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int LANES             = 3;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    // side information that rides along with every request
    typedef struct packed {
        t_branch          branch;
        logic             degen;
        logic [LANES-1:0] neg;
    } t_side;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // unsigned width of the square-root argument
    function automatic int arg_w(input int f);
        return max2(FIELD_W + 1, f) + 1;
    endfunction

    // radicand width, rounded up to an even count
    function automatic int rad_w(input int f);
        return arg_w(f) + f + ((arg_w(f) + f) & 1);
    endfunction

    function automatic int sqrt_w(input int f);
        return rad_w(f) >> 1;
    endfunction

    // quotient bits: enough to see anything above one
    function automatic int quo_w(input int f);
        return f + 3;
    endfunction

    function automatic int rem_w(input int f);
        return max2(FIELD_W + f + 2, sqrt_w(f) + 1 + quo_w(f)) + 1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rmq_front.sv =====
// first stage: trace, axis choice, square-root argument and the three off-diagonal terms
// depends on rmq_pkg
`default_nettype none

module rmq_front import rmq_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int UW = arg_w(FRACTION_BITS),
    localparam int AW = UW + 1,
    localparam int RN = rad_w(FRACTION_BITS),
    localparam int MW = FIELD_W + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [FIELD_W-1:0]      i_m00,
    input  logic signed [FIELD_W-1:0]      i_m01,
    input  logic signed [FIELD_W-1:0]      i_m02,
    input  logic signed [FIELD_W-1:0]      i_m10,
    input  logic signed [FIELD_W-1:0]      i_m11,
    input  logic signed [FIELD_W-1:0]      i_m12,
    input  logic signed [FIELD_W-1:0]      i_m20,
    input  logic signed [FIELD_W-1:0]      i_m21,
    input  logic signed [FIELD_W-1:0]      i_m22,
    output logic                           o_valid,
    output logic [RN-1:0]                  o_rad,
    output logic [LANES-1:0][MW-1:0]       o_mag,
    output t_side                          o_side
);

    logic signed [AW-1:0]  e00, e11, e22, trace, arg, one;
    logic signed [MW-1:0]  d [LANES];
    logic                  tpos;
    logic                  degen;
    t_branch               br;
    logic [LANES-1:0]      neg;
    logic [LANES-1:0][MW-1:0] mag;
    logic [RN-1:0]         rad;

    logic                  r_valid;
    logic [RN-1:0]         r_rad;
    logic [LANES-1:0][MW-1:0] r_mag;
    t_side                 r_side;

    always_comb begin
        e00   = AW'(i_m00);
        e11   = AW'(i_m11);
        e22   = AW'(i_m22);
        one   = AW'(1) <<< FRACTION_BITS;
        trace = e00 + e11 + e22;
        tpos  = !trace[AW-1] && (trace != '0);

        // strict compares so ties keep the lower row
        if (i_m00 < i_m11) begin
            br = (i_m11 < i_m22) ? BR_Z : BR_Y;
        end else begin
            br = (i_m00 < i_m22) ? BR_Z : BR_X;
        end

        case (br)
            BR_X: begin
                arg  = e00 - e11 - e22 + one;
                d[0] = MW'(i_m21) - MW'(i_m12);
                d[1] = MW'(i_m10) + MW'(i_m01);
                d[2] = MW'(i_m20) + MW'(i_m02);
            end
            BR_Y: begin
                arg  = e11 - e22 - e00 + one;
                d[0] = MW'(i_m02) - MW'(i_m20);
                d[1] = MW'(i_m21) + MW'(i_m12);
                d[2] = MW'(i_m01) + MW'(i_m10);
            end
            default: begin
                arg  = e22 - e00 - e11 + one;
                d[0] = MW'(i_m10) - MW'(i_m01);
                d[1] = MW'(i_m02) + MW'(i_m20);
                d[2] = MW'(i_m12) + MW'(i_m21);
            end
        endcase

        degen = 1'b0;
        if (tpos) begin
            br   = BR_TRACE;
            arg  = trace + one;
            d[0] = MW'(i_m21) - MW'(i_m12);
            d[1] = MW'(i_m02) - MW'(i_m20);
            d[2] = MW'(i_m10) - MW'(i_m01);
        end else if (arg[AW-1] || (arg == '0)) begin
            // clamp a non-positive argument to one lsb
            degen = 1'b1;
            arg   = AW'(1);
        end

        rad = RN'(arg[UW-1:0]) << FRACTION_BITS;

        for (int l = 0; l < LANES; l++) begin
            neg[l] = d[l][MW-1];
            mag[l] = neg[l] ? MW'(-d[l]) : MW'(d[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad         <= rad;
            r_mag         <= mag;
            r_side.branch <= br;
            r_side.degen  <= degen;
            r_side.neg    <= neg;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_mag   = r_mag;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/rmq_sqrt_cell.sv =====
// one cell of the square-root chain: takes two radicand bits, yields one root bit
// depends on rmq_pkg
`default_nettype none

module rmq_sqrt_cell import rmq_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int RN  = rad_w(FRACTION_BITS),
    localparam int SW  = sqrt_w(FRACTION_BITS),
    localparam int RMW = SW + 2,
    localparam int MW  = FIELD_W + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [RN-1:0]             i_rad,
    input  logic [RMW-1:0]            i_rem,
    input  logic [SW-1:0]             i_root,
    input  logic [LANES-1:0][MW-1:0]  i_mag,
    input  t_side                     i_side,
    output logic                      o_valid,
    output logic [RN-1:0]             o_rad,
    output logic [RMW-1:0]            o_rem,
    output logic [SW-1:0]             o_root,
    output logic [LANES-1:0][MW-1:0]  o_mag,
    output t_side                     o_side
);

    logic [RMW+1:0]           cur, trial;
    logic                     ge;
    logic [RMW-1:0]           n_rem;
    logic [SW-1:0]            n_root;

    logic                     r_valid;
    logic [RN-1:0]            r_rad;
    logic [RMW-1:0]           r_rem;
    logic [SW-1:0]            r_root;
    logic [LANES-1:0][MW-1:0] r_mag;
    t_side                    r_side;

    always_comb begin
        cur    = {i_rem, i_rad[RN-1 -: 2]};
        trial  = (RMW+2)'({i_root, 2'b01});
        ge     = (cur >= trial);
        n_rem  = ge ? RMW'(cur - trial) : RMW'(cur);
        n_root = {i_root[SW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= i_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_mag  <= i_mag;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_mag   = r_mag;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/rmq_div_cell.sv =====
// one cell of the divider chain: one quotient bit for each of the three lanes
// depends on rmq_pkg
`default_nettype none

module rmq_div_cell import rmq_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int SHIFT         = 0,
    localparam int SW = sqrt_w(FRACTION_BITS),
    localparam int QW = quo_w(FRACTION_BITS),
    localparam int CW = rem_w(FRACTION_BITS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [LANES-1:0][CW-1:0]  i_rem,
    input  logic [LANES-1:0][QW-1:0]  i_quo,
    input  logic [SW-1:0]             i_s,
    input  t_side                     i_side,
    output logic                      o_valid,
    output logic [LANES-1:0][CW-1:0]  o_rem,
    output logic [LANES-1:0][QW-1:0]  o_quo,
    output logic [SW-1:0]             o_s,
    output t_side                     o_side
);

    logic [CW-1:0]            den_sh;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][CW-1:0] n_rem;
    logic [LANES-1:0][QW-1:0] n_quo;

    logic                     r_valid;
    logic [LANES-1:0][CW-1:0] r_rem;
    logic [LANES-1:0][QW-1:0] r_quo;
    logic [SW-1:0]            r_s;
    t_side                    r_side;

    // divisor is 2*s, placed at this cell's quotient bit
    always_comb begin
        den_sh = CW'(i_s) << (SHIFT + 1);
        for (int l = 0; l < LANES; l++) begin
            ge[l]    = (i_rem[l] >= den_sh);
            n_rem[l] = ge[l] ? (i_rem[l] - den_sh) : i_rem[l];
            n_quo[l] = {i_quo[l][QW-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_s    <= i_s;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_s     = r_s;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/rmq_back.sv =====
// last stage: saturation, lane to component mapping and the output register
// depends on rmq_pkg
`default_nettype none

module rmq_back import rmq_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int SW = sqrt_w(FRACTION_BITS),
    localparam int QW = quo_w(FRACTION_BITS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [LANES-1:0][QW-1:0]  i_quo,
    input  logic [SW-1:0]             i_s,
    input  t_side                     i_side,
    output logic                      o_valid,
    output logic signed [FIELD_W-1:0] o_qx,
    output logic signed [FIELD_W-1:0] o_qy,
    output logic signed [FIELD_W-1:0] o_qz,
    output logic signed [FIELD_W-1:0] o_qw,
    output logic [1:0]                o_branch,
    output logic                      o_degenerate
);

    localparam int    XW     = max2(QW, SW) + 1;
    localparam longint ONE_L = longint'(1) << FRACTION_BITS;
    localparam longint PMAX  = (longint'(1) << (FIELD_W - 1)) - 1;
    localparam longint NMAX  = longint'(1) << (FIELD_W - 1);
    localparam longint CAPP  = (ONE_L < PMAX) ? ONE_L : PMAX;
    localparam longint CAPN  = (ONE_L < NMAX) ? ONE_L : NMAX;

    logic [XW-1:0]              ext, cap, lim;
    logic signed [FIELD_W-1:0]  lv [LANES];
    logic signed [FIELD_W-1:0]  mv;
    logic signed [FIELD_W-1:0]  n_qx, n_qy, n_qz, n_qw;

    logic                       r_valid;
    logic signed [FIELD_W-1:0]  r_qx, r_qy, r_qz, r_qw;
    t_branch                    r_branch;
    logic                       r_degen;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            ext   = XW'(i_quo[l]);
            cap   = i_side.neg[l] ? XW'(CAPN) : XW'(CAPP);
            lim   = (ext > cap) ? cap : ext;
            lv[l] = i_side.neg[l] ? -FIELD_W'(lim) : FIELD_W'(lim);
        end
        ext = XW'(i_s >> 1);
        cap = XW'(CAPP);
        lim = (ext > cap) ? cap : ext;
        mv  = FIELD_W'(lim);

        // lane 0 is w on the axis branches
        case (i_side.branch)
            BR_TRACE: begin
                n_qx = lv[0]; n_qy = lv[1]; n_qz = lv[2]; n_qw = mv;
            end
            BR_X: begin
                n_qw = lv[0]; n_qy = lv[1]; n_qz = lv[2]; n_qx = mv;
            end
            BR_Y: begin
                n_qw = lv[0]; n_qz = lv[1]; n_qx = lv[2]; n_qy = mv;
            end
            default: begin
                n_qw = lv[0]; n_qx = lv[1]; n_qy = lv[2]; n_qz = mv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qx     <= n_qx;
            r_qy     <= n_qy;
            r_qz     <= n_qz;
            r_qw     <= n_qw;
            r_branch <= i_side.branch;
            r_degen  <= i_side.degen;
        end
    end

    assign o_valid      = r_valid;
    assign o_qx         = r_qx;
    assign o_qy         = r_qy;
    assign o_qz         = r_qz;
    assign o_qw         = r_qw;
    assign o_branch     = r_branch;
    assign o_degenerate = r_degen;

endmodule

`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// rotation matrix to unit quaternion (shepperd), top level
// depends on rmq_pkg, rmq_front, rmq_sqrt_cell, rmq_div_cell, rmq_back
//
// usage:
// - input channel i_valid / o_stall carries one 3x3 matrix per request (i_m00..i_m22,
//   signed, FRACTION_BITS fraction bits); a request is taken when i_valid is high
//   and o_stall is low
// - output channel o_valid / i_stall carries qx, qy, qz, qw, branch and degenerate;
//   a result is taken when o_valid is high and i_stall is low
// - throughput: one request per cycle while o_stall is low; the pipeline is a front
//   stage, a chain of sqrt cells (one root bit each), a rounding-numerator stage, a
//   chain of divider cells (one quotient bit each, three lanes side by side) and an
//   output register
// - while a result waits in the output register and i_stall is high, the whole chain
//   holds and o_stall is raised; otherwise every cell advances each cycle
// - reset (i_rst_n low, synchronous) clears all valid bits; nothing is in flight after it
// - no configuration and no state between requests
`default_nettype none

module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [FIELD_W-1:0] i_m00,
    input  logic signed [FIELD_W-1:0] i_m01,
    input  logic signed [FIELD_W-1:0] i_m02,
    input  logic signed [FIELD_W-1:0] i_m10,
    input  logic signed [FIELD_W-1:0] i_m11,
    input  logic signed [FIELD_W-1:0] i_m12,
    input  logic signed [FIELD_W-1:0] i_m20,
    input  logic signed [FIELD_W-1:0] i_m21,
    input  logic signed [FIELD_W-1:0] i_m22,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [FIELD_W-1:0] o_qx,
    output logic signed [FIELD_W-1:0] o_qy,
    output logic signed [FIELD_W-1:0] o_qz,
    output logic signed [FIELD_W-1:0] o_qw,
    output logic [1:0]                o_branch,
    output logic                      o_degenerate
);

    localparam int RN  = rad_w(FRACTION_BITS);
    localparam int SW  = sqrt_w(FRACTION_BITS);
    localparam int RMW = SW + 2;
    localparam int MW  = FIELD_W + 1;
    localparam int QW  = quo_w(FRACTION_BITS);
    localparam int CW  = rem_w(FRACTION_BITS);

    logic en;

    logic                     s_valid [SW+1];
    logic [RN-1:0]            s_rad   [SW+1];
    logic [RMW-1:0]           s_rem   [SW+1];
    logic [SW-1:0]            s_root  [SW+1];
    logic [LANES-1:0][MW-1:0] s_mag   [SW+1];
    t_side                    s_side  [SW+1];

    logic                     r_prep_valid;
    logic [LANES-1:0][CW-1:0] r_prep_num;
    logic [SW-1:0]            r_prep_s;
    t_side                    r_prep_side;
    logic [LANES-1:0][CW-1:0] n_prep_num;

    logic                     d_valid [QW+1];
    logic [LANES-1:0][CW-1:0] d_rem   [QW+1];
    logic [LANES-1:0][QW-1:0] d_quo   [QW+1];
    logic [SW-1:0]            d_s     [QW+1];
    t_side                    d_side  [QW+1];

    // the chain moves as one unless a finished result is held
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    rmq_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .o_valid (s_valid[0]),
        .o_rad   (s_rad[0]),
        .o_mag   (s_mag[0]),
        .o_side  (s_side[0])
    );

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        rmq_sqrt_cell #(.FRACTION_BITS(FRACTION_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[g]),
            .i_rad   (s_rad[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_mag   (s_mag[g]),
            .i_side  (s_side[g]),
            .o_valid (s_valid[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_mag   (s_mag[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    // numerator with half the divisor added for round to nearest
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_prep_num[l] = (CW'(s_mag[SW][l]) << FRACTION_BITS) + CW'(s_root[SW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (en) begin
            r_prep_valid <= s_valid[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep_num  <= n_prep_num;
            r_prep_s    <= s_root[SW];
            r_prep_side <= s_side[SW];
        end
    end

    assign d_valid[0] = r_prep_valid;
    assign d_rem[0]   = r_prep_num;
    assign d_quo[0]   = '0;
    assign d_s[0]     = r_prep_s;
    assign d_side[0]  = r_prep_side;

    for (genvar g = 0; g < QW; g++) begin : g_div
        rmq_div_cell #(.FRACTION_BITS(FRACTION_BITS), .SHIFT(QW - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_valid[g]),
            .i_rem   (d_rem[g]),
            .i_quo   (d_quo[g]),
            .i_s     (d_s[g]),
            .i_side  (d_side[g]),
            .o_valid (d_valid[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_quo   (d_quo[g+1]),
            .o_s     (d_s[g+1]),
            .o_side  (d_side[g+1])
        );
    end

    rmq_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (d_valid[QW]),
        .i_quo        (d_quo[QW]),
        .i_s          (d_s[QW]),
        .i_side       (d_side[QW]),
        .o_valid      (o_valid),
        .o_qx         (o_qx),
        .o_qy         (o_qy),
        .o_qz         (o_qz),
        .o_qw         (o_qw),
        .o_branch     (o_branch),
        .o_degenerate (o_degenerate)
    );

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_degen_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_branch != BR_TRACE))
        else $error("degenerate flag on the trace branch");

    a_main_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_branch == BR_TRACE && !o_qw[FIELD_W-1]) ||
                     (o_branch == BR_X && !o_qx[FIELD_W-1]) ||
                     (o_branch == BR_Y && !o_qy[FIELD_W-1]) ||
                     (o_branch == BR_Z && !o_qz[FIELD_W-1])))
        else $error("sqrt-derived component is negative");

    a_hold_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("request taken while the chain is frozen");
`endif

endmodule

`default_nettype wire

// ===== tb/rmq_checker.sv =====
// result checker for the rotation matrix to quaternion unit: watches both channels,
// predicts each quaternion from the accepted matrix and compares field by field
// depends on rmq_pkg
`timescale 1ns / 100ps

module rmq_checker import rmq_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      i_in_stall,
    input logic signed [FIELD_W-1:0] i_m00, i_m01, i_m02,
    input logic signed [FIELD_W-1:0] i_m10, i_m11, i_m12,
    input logic signed [FIELD_W-1:0] i_m20, i_m21, i_m22,
    input logic                      i_out_valid,
    input logic                      i_out_stall,
    input logic signed [FIELD_W-1:0] i_qx, i_qy, i_qz, i_qw,
    input logic [1:0]                i_branch,
    input logic                      i_degenerate,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic signed [FIELD_W-1:0] qx, qy, qz, qw;
        t_branch                   branch;
        logic                      degen;
    } t_quat;

    t_quat quat_fifo[$];
    int    mismatches;
    int    pend;

    assign o_fail_count = mismatches;
    assign o_pending    = pend;

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_div(input longint d, input longint unsigned den);
        longint unsigned mag, quo;
        mag = (d < 0) ? -d : d;
        quo = ((mag << FRACTION_BITS) + den / 2) / den;
        return (d < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic logic signed [FIELD_W-1:0] clip(input longint v);
        longint one;
        one = longint'(1) << FRACTION_BITS;
        if (v > one) v = one;
        if (v < -one) v = -one;
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[FIELD_W-1:0];
    endfunction

    function automatic t_quat shepperd(input longint m[3][3]);
        longint          one, tr, arg;
        longint          q[4];
        longint unsigned s;
        int              i, j, k;
        t_quat           r;
        one     = longint'(1) << FRACTION_BITS;
        tr      = m[0][0] + m[1][1] + m[2][2];
        r.degen = 1'b0;
        if (tr > 0) begin
            s        = int_sqrt(longint'(tr + one) << FRACTION_BITS);
            q[3]     = s >> 1;
            q[0]     = round_div(m[2][1] - m[1][2], 2 * s);
            q[1]     = round_div(m[0][2] - m[2][0], 2 * s);
            q[2]     = round_div(m[1][0] - m[0][1], 2 * s);
            r.branch = BR_TRACE;
        end else begin
            if (m[0][0] < m[1][1]) i = (m[1][1] < m[2][2]) ? 2 : 1;
            else i = (m[0][0] < m[2][2]) ? 2 : 0;
            j   = (i + 1) % 3;
            k   = (i + 2) % 3;
            arg = m[i][i] - m[j][j] - m[k][k] + one;
            if (arg <= 0) begin
                arg     = 1;
                r.degen = 1'b1;
            end
            s    = int_sqrt(arg << FRACTION_BITS);
            q[i] = s >> 1;
            q[3] = round_div(m[k][j] - m[j][k], 2 * s);
            q[j] = round_div(m[j][i] + m[i][j], 2 * s);
            q[k] = round_div(m[k][i] + m[i][k], 2 * s);
            case (i)
                0: r.branch = BR_X;
                1: r.branch = BR_Y;
                default: r.branch = BR_Z;
            endcase
        end
        r.qx = clip(q[0]);
        r.qy = clip(q[1]);
        r.qz = clip(q[2]);
        r.qw = clip(q[3]);
        return r;
    endfunction

    initial begin
        mismatches = 0;
        pend       = 0;
    end

    always @(posedge i_clk) begin
        longint m[3][3];
        t_quat  want, got;
        if (i_rst_n && i_valid && !i_in_stall) begin
            m = '{'{i_m00, i_m01, i_m02}, '{i_m10, i_m11, i_m12}, '{i_m20, i_m21, i_m22}};
            quat_fifo.push_back(shepperd(m));
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            got = '{i_qx, i_qy, i_qz, i_qw, t_branch'(i_branch), i_degenerate};
            if (quat_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = quat_fifo.pop_front();
                if (want !== got) begin
                    mismatches++;
                    if (mismatches <= 10) $display("exp %p got %p", want, got);
                end
            end
        end
        pend = quat_fifo.size();
    end

endmodule

// ===== tb/tb_rotation_matrix_to_quaternion_unit.sv =====
// testbench top for rotation_matrix_to_quaternion_unit: drives directed and random
// matrices with random gaps and stalls; verdict from rmq_checker
// depends on rmq_pkg, rmq_checker and the unit under test
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_unit;
    import rmq_pkg::*;

    localparam int ONE = 65536;

    logic clk = 1'b0, rst_n = 1'b0;
    logic valid = 1'b0, out_stall = 1'b0;
    logic in_stall, out_valid, degen;
    logic signed [FIELD_W-1:0] m[9];
    logic signed [FIELD_W-1:0] qx, qy, qz, qw;
    logic [1:0] branch;
    int fails, pending;

    initial foreach (m[n]) m[n] = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rotation_matrix_to_quaternion_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(valid), .o_stall(in_stall),
        .i_m00(m[0]), .i_m01(m[1]), .i_m02(m[2]), .i_m10(m[3]), .i_m11(m[4]),
        .i_m12(m[5]), .i_m20(m[6]), .i_m21(m[7]), .i_m22(m[8]),
        .o_valid(out_valid), .i_stall(out_stall), .o_qx(qx), .o_qy(qy), .o_qz(qz),
        .o_qw(qw), .o_branch(branch), .o_degenerate(degen)
    );

    rmq_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(valid), .i_in_stall(in_stall),
        .i_m00(m[0]), .i_m01(m[1]), .i_m02(m[2]), .i_m10(m[3]), .i_m11(m[4]),
        .i_m12(m[5]), .i_m20(m[6]), .i_m21(m[7]), .i_m22(m[8]),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_qx(qx), .i_qy(qy),
        .i_qz(qz), .i_qw(qw), .i_branch(branch), .i_degenerate(degen),
        .o_fail_count(fails), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // receiver stalls, with calm stretches
    always @(posedge clk) begin
        int r;
        r = $urandom_range(0, 999);
        if ((r % 250) < 60) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 99) < 25) || (r > 985);
    end

    function automatic logic signed [FIELD_W-1:0] rand_entry();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return FIELD_W'($urandom());
        if (r == 1) return FIELD_W'($urandom_range(0, 1) ? ONE : -ONE);
        return FIELD_W'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endfunction

    // rotation-like matrix: diagonal near one of the four shepperd branches; fully random when noise is set
    task automatic make_request(input bit noise);
        int ax;
        logic signed [FIELD_W-1:0] v[9];
        foreach (v[n]) v[n] = rand_entry();
        if (!noise) begin
            ax = $urandom_range(0, 3);
            v[0] = (ax == 1) ? FIELD_W'($urandom_range(ONE / 2, ONE)) :
                               FIELD_W'(-$signed($urandom_range(0, ONE)));
            v[4] = (ax == 2) ? FIELD_W'($urandom_range(ONE / 2, ONE)) :
                               FIELD_W'(-$signed($urandom_range(0, ONE)));
            v[8] = (ax == 3) ? FIELD_W'($urandom_range(ONE / 2, ONE)) :
                               FIELD_W'(-$signed($urandom_range(0, ONE)));
            if (ax == 0) begin
                v[0] = FIELD_W'($urandom_range(ONE / 3, ONE));
                v[4] = FIELD_W'($urandom_range(0, ONE));
                v[8] = FIELD_W'($urandom_range(0, ONE));
            end
        end
        foreach (m[n]) m[n] <= v[n];
    endtask

    task automatic send(input logic signed [FIELD_W-1:0] v[9]);
        int g;
        g = gap_len();
        if (g > 0) begin
            valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        foreach (m[n]) m[n] <= v[n];
        valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random(input bit noise);
        int g;
        g = gap_len();
        if (g > 0) begin
            valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        make_request(noise);
        valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        logic signed [FIELD_W-1:0] v[9];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};            send(v);
        v = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};          send(v);
        v = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};          send(v);
        v = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};          send(v);
        // ties on the diagonal
        v = '{0, ONE, 0, -ONE, 0, 0, 0, 0, 0};             send(v);
        v = '{-100, 5, 7, 9, -100, 3, 1, 2, -100};         send(v);
        v = '{-ONE, 0, 0, 0, 0, 0, 0, 0, 0};               send(v);
        // non-positive trace, so an axis branch is taken
        v = '{-ONE, 3, 4, 5, -ONE, 6, 7, 8, ONE};          send(v);
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send(v);
        v = '{-ONE, ONE, ONE, ONE, -ONE, ONE, ONE, ONE, -ONE}; send(v);
        // full field extremes outside +-one, single-lsb entries and alternating bit patterns
        v = '{131071, 131071, -131072, -131072, 131071, 131071, -131072, 131071, 131071};
        send(v);
        v = '{-131072, 131071, -131072, 131071, -131072, -131072, 131071, -131072, -131072};
        send(v);
        v = '{1, -1, 0, 1, 0, -1, -1, 1, 0};               send(v);
        v = '{18'sh2AAAA, 18'sh15555, 18'sh2AAAA, 18'sh15555, 18'sh15555,
              18'sh2AAAA, 18'sh15555, 18'sh2AAAA, 18'sh15555};
        send(v);
        for (int n = 0; n < 1400; n++) begin
            if (n == 700) begin
                valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            send_random($urandom_range(0, 9) < 2);
        end
        valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fails == 0 && pending == 0) begin
            $display("rotation_matrix_to_quaternion_unit: match");
        end else begin
            $display("rotation_matrix_to_quaternion_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("rotation_matrix_to_quaternion_unit: mismatch");
        $finish;
    end

endmodule
